// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Same-cycle implication built on the clocked property.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    `ASSERT_PROP(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// ----- rtl/lmfs_pkg.sv -----
package lmfs_pkg;

    // Frame and transfer geometry
    localparam int ROWS           = 8;
    localparam int COLS           = 32;
    localparam int BYTES_PER_CHIP = 16;

    localparam int ROW_W = 3;
    localparam int COL_W = $clog2(COLS);
    localparam int BI_W  = $clog2(2 * BYTES_PER_CHIP);
    localparam int J_W   = $clog2(BYTES_PER_CHIP + 1);
    localparam int CFG_W = 8;

    // Brightness and reset codes
    localparam logic [7:0] BRIGHT_OFF    = 8'h80;
    localparam logic [7:0] BRIGHT_BASE   = 8'h88;
    localparam logic [3:0] MAX_LEVEL     = 4'd8;
    localparam logic [7:0] START_CMD_RST = 8'hC0;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_CLEAR   = 2'd1,
        CMD_REFRESH = 2'd2,
        CMD_BRIGHT  = 2'd3
    } cmd_t;

    typedef enum logic [0:0] {
        CFG_START_CMD    = 1'b0,
        CFG_COMMON_ANODE = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_CLEAR,
        JOB_REFRESH,
        JOB_BRIGHT
    } job_op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BRIGHT,
        BK_REFRESH
    } back_state_t;

    // One classified item travelling from front to back
    typedef struct packed {
        job_op_t            op;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               pixel_on;
        logic               time_synced;
        logic               link_connected;
        logic [7:0]         bright_byte;
    } job_t;

    // Queue handshake between front and back
    typedef struct packed {
        logic valid;
        logic ready;
    } q_hs_t;

endpackage

// ----- rtl/lmfs_if.sv -----
interface lmfs_in_if;
    import lmfs_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [2:0] row;
    logic [4:0] col;
    logic       pixel_on;
    logic       time_synced;
    logic       link_connected;
    logic [3:0] level;

    modport source (
        output valid, cmd, row, col, pixel_on, time_synced, link_connected, level,
        input  ready
    );
    modport sink (
        input  valid, cmd, row, col, pixel_on, time_synced, link_connected, level,
        output ready
    );
endinterface

interface lmfs_out_if;
    import lmfs_pkg::*;

    logic       valid;
    logic       ready;
    logic       chip;
    logic [7:0] byte_value;
    logic       opens_transfer;
    logic       closes_transfer;
    logic       last;

    modport source (
        output valid, chip, byte_value, opens_transfer, closes_transfer, last,
        input  ready
    );
    modport sink (
        input  valid, chip, byte_value, opens_transfer, closes_transfer, last,
        output ready
    );
endinterface

// ----- rtl/lmfs_queue.sv -----
module lmfs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lmfs_pkg::job_t push_job,
    input  logic          pop,
    output lmfs_pkg::q_hs_t hs,
    output lmfs_pkg::job_t head_job
);
    import lmfs_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // Status toward both sides
    always_comb
    begin
        hs.valid = (count_reg != 2'd0);
        hs.ready = (count_reg != 2'd2);
        head_job = mem_reg[rd_ptr_reg];
    end

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/lmfs_front.sv -----
module lmfs_front (
    lmfs_in_if.sink        in_ch,
    input  lmfs_pkg::q_hs_t q_hs,
    output logic           push,
    output lmfs_pkg::job_t push_job
);
    import lmfs_pkg::*;

    logic keep;

    // Accept whenever the queue has room; drop items that do nothing
    always_comb
    begin
        in_ch.ready = q_hs.ready;
        keep        = 1'b1;
        push_job.op             = JOB_WRITE;
        push_job.row            = in_ch.row;
        push_job.col            = COL_W'(in_ch.col);
        push_job.pixel_on       = in_ch.pixel_on;
        push_job.time_synced    = in_ch.time_synced;
        push_job.link_connected = in_ch.link_connected;
        push_job.bright_byte    = BRIGHT_OFF;

        case (cmd_t'(in_ch.cmd))
            CMD_WRITE:
            begin
                push_job.op = JOB_WRITE;
                keep        = (32'(in_ch.col) < COLS);
            end
            CMD_CLEAR:
            begin
                push_job.op = JOB_CLEAR;
            end
            CMD_REFRESH:
            begin
                push_job.op = JOB_REFRESH;
            end
            CMD_BRIGHT:
            begin
                push_job.op = JOB_BRIGHT;
                keep        = (in_ch.level <= MAX_LEVEL);
                if (in_ch.level != 4'd0)
                begin
                    push_job.bright_byte = BRIGHT_BASE + 8'(in_ch.level) - 8'd1;
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase

        push = in_ch.valid && q_hs.ready && keep;
    end

endmodule

// ----- rtl/lmfs_back.sv -----
module lmfs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [lmfs_pkg::CFG_W-1:0]    cfg_data,
    input  lmfs_pkg::q_hs_t               q_hs,
    input  lmfs_pkg::job_t                head_job,
    output logic                          pop,
    lmfs_out_if.source                    out_ch
);
    import lmfs_pkg::*;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic             chip_reg;
    logic             chip_next;
    logic [J_W-1:0]   j_reg;
    logic [J_W-1:0]   j_next;
    logic [7:0]       bbyte_reg;
    logic [7:0]       bbyte_next;
    logic [COLS-1:0]  store_reg  [ROWS];
    logic [COLS-1:0]  store_next [ROWS];
    logic [7:0]       start_cmd_reg;
    logic             common_anode_reg;

    logic             out_valid_reg;
    logic             chip_out_reg;
    logic [7:0]       byte_out_reg;
    logic             opens_out_reg;
    logic             closes_out_reg;
    logic             last_out_reg;

    logic             ld;
    logic             emit;
    logic             e_chip;
    logic [7:0]       e_byte;
    logic             e_open;
    logic             e_close;
    logic             e_last;
    logic [BI_W-1:0]  b_idx;
    logic [7:0]       packed_byte;

    assign ld = !out_valid_reg || out_ch.ready;

    // Byte index within the frame for the current data byte
    assign b_idx = BI_W'(j_reg - J_W'(1)) + (chip_reg ? BI_W'(BYTES_PER_CHIP) : BI_W'(0));

    // Pack one byte from the store in the chosen order
    always_comb
    begin
        logic [BI_W-1:0]  c;
        logic [ROW_W-1:0] r;
        for (int k = 0; k < 8; k++)
        begin
            if (common_anode_reg)
            begin
                c = b_idx;
                r = ROW_W'(k);
            end
            else
            begin
                c = {b_idx[BI_W-1:3], 3'(k)};
                r = b_idx[2:0];
            end
            packed_byte[k] = (32'(c) < COLS) ? store_reg[r][COL_W'(c)] : 1'b0;
        end
    end

    // Sequence items out of the queue and update the store
    always_comb
    begin
        state_next = state_reg;
        chip_next  = chip_reg;
        j_next     = j_reg;
        bbyte_next = bbyte_reg;
        store_next = store_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        e_chip     = 1'b0;
        e_byte     = start_cmd_reg;
        e_open     = 1'b0;
        e_close    = 1'b0;
        e_last     = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_hs.valid)
                begin
                    case (head_job.op)
                        JOB_WRITE:
                        begin
                            pop = 1'b1;
                            store_next[head_job.row][head_job.col] = head_job.pixel_on;
                        end
                        JOB_CLEAR:
                        begin
                            pop = 1'b1;
                            for (int r = 0; r < ROWS; r++)
                            begin
                                store_next[r] = '0;
                            end
                        end
                        JOB_BRIGHT:
                        begin
                            if (ld)
                            begin
                                pop        = 1'b1;
                                emit       = 1'b1;
                                e_byte     = head_job.bright_byte;
                                e_open     = 1'b1;
                                e_close    = 1'b1;
                                bbyte_next = head_job.bright_byte;
                                state_next = BK_BRIGHT;
                            end
                        end
                        JOB_REFRESH:
                        begin
                            if (ld)
                            begin
                                pop  = 1'b1;
                                store_next[ROWS-1][0]  = !head_job.time_synced;
                                store_next[0][COLS-1]  = head_job.link_connected;
                                emit       = 1'b1;
                                e_open     = 1'b1;
                                chip_next  = 1'b0;
                                j_next     = J_W'(1);
                                state_next = BK_REFRESH;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_BRIGHT:
            begin
                if (ld)
                begin
                    emit       = 1'b1;
                    e_chip     = 1'b1;
                    e_byte     = bbyte_reg;
                    e_open     = 1'b1;
                    e_close    = 1'b1;
                    e_last     = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            BK_REFRESH:
            begin
                if (ld)
                begin
                    emit   = 1'b1;
                    e_chip = chip_reg;
                    if (j_reg == J_W'(0))
                    begin
                        e_open = 1'b1;
                    end
                    else
                    begin
                        e_byte  = packed_byte;
                        e_close = (j_reg == J_W'(BYTES_PER_CHIP));
                        e_last  = e_close && chip_reg;
                    end
                    if (j_reg == J_W'(BYTES_PER_CHIP))
                    begin
                        j_next = J_W'(0);
                        if (chip_reg)
                        begin
                            state_next = BK_IDLE;
                        end
                        else
                        begin
                            chip_next = 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + J_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Hold control state, store and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            chip_reg         <= 1'b0;
            j_reg            <= '0;
            out_valid_reg    <= 1'b0;
            start_cmd_reg    <= START_CMD_RST;
            common_anode_reg <= 1'b0;
            for (int r = 0; r < ROWS; r++)
            begin
                store_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            chip_reg  <= chip_next;
            j_reg     <= j_next;
            store_reg <= store_next;
            if (ld)
            begin
                out_valid_reg <= emit;
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_START_CMD:    start_cmd_reg    <= cfg_data;
                    CFG_COMMON_ANODE: common_anode_reg <= cfg_data[0];
                    default:          start_cmd_reg    <= start_cmd_reg;
                endcase
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        bbyte_reg <= bbyte_next;
        if (ld && emit)
        begin
            chip_out_reg   <= e_chip;
            byte_out_reg   <= e_byte;
            opens_out_reg  <= e_open;
            closes_out_reg <= e_close;
            last_out_reg   <= e_last;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.chip            = chip_out_reg;
    assign out_ch.byte_value      = byte_out_reg;
    assign out_ch.opens_transfer  = opens_out_reg;
    assign out_ch.closes_transfer = closes_out_reg;
    assign out_ch.last            = last_out_reg;

endmodule

// ----- rtl/led_matrix_frame_serializer.sv -----
// Order: a refresh or brightness item's first byte passes the queue, then the output register;
// a pixel write or clear passes the queue before the back end updates the frame store.
// Throughput: writes and clears emit no bytes; a refresh holds the back end for 34 output bytes
// and a brightness item for 2, one per cycle unless stalled; a 2-entry queue absorbs input.
// Reset: frame store all zeros, start command 0xC0, common cathode order, queue and output empty.
module led_matrix_frame_serializer (
    input  logic                       clk,
    input  logic                       rst_n,
    lmfs_in_if.sink                    in_ch,
    lmfs_out_if.source                 out_ch,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [lmfs_pkg::CFG_W-1:0] cfg_data
);
    import lmfs_pkg::*;

    q_hs_t q_hs;
    logic  push;
    logic  pop;
    job_t  push_job;
    job_t  head_job;

    lmfs_front u_front (
        .in_ch    (in_ch),
        .q_hs     (q_hs),
        .push     (push),
        .push_job (push_job)
    );

    lmfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .hs       (q_hs),
        .head_job (head_job)
    );

    lmfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_hs      (q_hs),
        .head_job  (head_job),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule

// ----- rtl/lmfs_checker.sv -----
`include "assert_macros.svh"

module lmfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       chip,
    input logic [7:0] byte_value,
    input logic       opens_transfer,
    input logic       closes_transfer,
    input logic       last
);

    // A stalled item keeps its payload
    `ASSERT_PROP(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(byte_value) && $stable(chip))

    // The final byte of an item goes to the second chip and ends a transfer
    `ASSERT_IMPLIES(a_last_end, clk, rst_n, out_valid && last, chip && closes_transfer)

    // A one-byte transfer is always a display-control byte
    `ASSERT_IMPLIES(a_ctrl_byte, clk, rst_n, out_valid && opens_transfer && closes_transfer, byte_value[7:4] == 4'h8)

endmodule

bind led_matrix_frame_serializer lmfs_checker u_lmfs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .chip            (out_ch.chip),
    .byte_value      (out_ch.byte_value),
    .opens_transfer  (out_ch.opens_transfer),
    .closes_transfer (out_ch.closes_transfer),
    .last            (out_ch.last)
);
